[hdl/base64_stream_decoder_top_defines.svh]
// Assertion macros used by the base64 stream decoder core.
`ifndef BASE64_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE64_STREAM_DECODER_TOP_DEFINES_SVH

// Check a condition on every clock edge outside reset.
`define B64D_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define B64D_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/b64d_pkg.sv]
// Types, constants and the sextet lookup for the base64 stream decoder.
`default_nettype none
package b64d_pkg;

  localparam int unsigned CntW = 13;
  localparam logic [CntW-1:0] MaxTotal = 13'd4096;
  localparam logic [CntW-1:0] LimitReset = 13'd64;

  localparam logic [1:0] MODE_STD    = 2'd0;
  localparam logic [1:0] MODE_URL    = 2'd1;
  localparam logic [1:0] MODE_STRICT = 2'd2;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_LIMIT = 2'd1;

  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_BAD_TAIL = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [CntW-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic            byte_valid;
    logic            done_res;
    status_t         status;
    logic [CntW-1:0] byte_total;
  } res_t;

  // Map a character to {good, 6-bit value}; both alphabets give 62 and 63.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == CH_PLUS || c == CH_DASH) begin
      r = {1'b1, 6'd62};
    end else if (c == CH_SLASH || c == CH_USCORE) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/b64d_cfg.sv]
// Configuration registers of the base64 stream decoder, with limit clamp.
`default_nettype none
module b64d_cfg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [12:0]           cfg_data,
  output      b64d_pkg::cfg_t        cfg
);
  import b64d_pkg::*;

  logic [1:0]      mode_r,  mode_nxt;
  logic [CntW-1:0] limit_r, limit_nxt;

  always_comb begin
    mode_nxt  = mode_r;
    limit_nxt = limit_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:  mode_nxt  = cfg_data[1:0];
        CFG_LIMIT: limit_nxt = cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_STD;
      limit_r <= LimitReset;
    end else begin
      mode_r  <= mode_nxt;
      limit_r <= limit_nxt;
    end
  end

  // clamp the limit to the largest message total
  assign cfg.mode  = mode_r;
  assign cfg.limit = (limit_r > MaxTotal) ? MaxTotal : limit_r;

endmodule
`default_nettype wire

[hdl/b64d_core.sv]
// Per-character decode step and message state of the base64 stream decoder.
`default_nettype none
`include "base64_stream_decoder_top_defines.svh"
module b64d_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire b64d_pkg::item_t  item,
  input  wire b64d_pkg::cfg_t   cfg,
  output      logic             res_valid,
  output      b64d_pkg::res_t   res
);
  import b64d_pkg::*;

  logic [13:0]     acc_r,  acc_nxt;
  logic [3:0]      pend_r, pend_nxt;
  logic            pad_r,  pad_nxt;
  status_t         err_r,  err_nxt;
  logic [1:0]      cmod_r, cmod_nxt;
  logic [CntW-1:0] cnt_r,  cnt_nxt;

  logic       strict, skip_ws, good, use_ch, have_byte;
  logic [5:0] val;
  logic [7:0] c, dbyte;
  logic [13:0] acc_sh;

  assign c       = item.char_code;
  assign strict  = (cfg.mode == MODE_STRICT);
  assign skip_ws = (cfg.mode == MODE_STD);
  assign {good, val} = sextet_of(c);
  assign acc_sh  = {acc_r[7:0], val};

  always_comb begin
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    pad_nxt   = pad_r;
    err_nxt   = err_r;
    cmod_nxt  = cmod_r + 2'd1;
    cnt_nxt   = cnt_r;
    use_ch    = 1'b1;
    have_byte = 1'b0;
    dbyte     = 8'd0;

    if (err_r != ST_OK) begin
      use_ch = 1'b0;
    end else if (strict) begin
      if (c == CH_PLUS || c == CH_SLASH || c == CH_EQ || !good) begin
        err_nxt = ST_BAD_CHAR;
        use_ch  = 1'b0;
      end
    end else begin
      if (pad_r) begin
        use_ch = 1'b0;
      end else if (c == CH_EQ) begin
        pad_nxt = 1'b1;
        use_ch  = 1'b0;
      end else if (skip_ws && c <= CH_SPACE) begin
        use_ch = 1'b0;
      end else if (!good) begin
        err_nxt = ST_BAD_CHAR;
        use_ch  = 1'b0;
      end
    end

    if (use_ch) begin
      acc_nxt = acc_sh;
      // held bits decide where the completed byte sits
      case (pend_r)
        4'd6: begin
          dbyte    = acc_sh[11:4];
          pend_nxt = 4'd4;
        end
        4'd4: begin
          dbyte    = acc_sh[9:2];
          pend_nxt = 4'd2;
        end
        4'd2: begin
          dbyte    = acc_sh[7:0];
          pend_nxt = 4'd0;
        end
        default: begin
          pend_nxt = 4'd6;
        end
      endcase
      if (pend_r != 4'd0 && cnt_r < cfg.limit) begin
        have_byte = 1'b1;
        cnt_nxt   = cnt_r + 13'd1;
      end
    end

    if (item.is_last && strict && err_nxt == ST_OK) begin
      if (cmod_nxt == 2'd1) begin
        err_nxt = ST_BAD_LEN;
      end else if (cmod_nxt == 2'd2 && val[3:0] != 4'd0) begin
        err_nxt = ST_BAD_TAIL;
      end else if (cmod_nxt == 2'd3 && val[1:0] != 2'd0) begin
        err_nxt = ST_BAD_TAIL;
      end
    end

    res = '0;
    if (!item.is_last) begin
      res_valid      = have_byte;
      res.out_byte   = have_byte ? dbyte : 8'd0;
      res.byte_valid = have_byte;
    end else begin
      res_valid      = 1'b1;
      res.byte_valid = have_byte && (err_nxt == ST_OK);
      res.out_byte   = res.byte_valid ? dbyte : 8'd0;
      res.done_res   = 1'b1;
      res.status     = err_nxt;
      res.byte_total = (err_nxt == ST_OK) ? cnt_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= '0;
      pad_r  <= 1'b0;
      err_r  <= ST_OK;
      cmod_r <= '0;
      cnt_r  <= '0;
    end else if (step_en) begin
      if (item.is_last) begin
        // clear message state for the next message
        acc_r  <= '0;
        pend_r <= '0;
        pad_r  <= 1'b0;
        err_r  <= ST_OK;
        cmod_r <= '0;
        cnt_r  <= '0;
      end else begin
        acc_r  <= acc_nxt;
        pend_r <= pend_nxt;
        pad_r  <= pad_nxt;
        err_r  <= err_nxt;
        cmod_r <= cmod_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  `B64D_ASSERT_ALWAYS(a_pend_even, clk, rst_n, (pend_r[0] == 1'b0 && pend_r <= 4'd6), "pending bit count out of range")
  `B64D_ASSERT_ALWAYS(a_cnt_max, clk, rst_n, (cnt_r <= MaxTotal), "byte count above maximum")
  `B64D_ASSERT_SAME(a_no_byte_err, clk, rst_n, (step_en && err_r != ST_OK), (!res.byte_valid), "byte after error")
  `B64D_ASSERT_NEXT(a_clear_end, clk, rst_n, (step_en && item.is_last), (cnt_r == '0 && err_r == ST_OK && pend_r == 4'd0), "message state not cleared")

endmodule
`default_nettype wire

[hdl/base64_stream_decoder_top.sv]
// Top level of the base64 stream decoder: input stage, result stage, wiring.
//
//  channel  direction  handshake               payload
//  in_      sink       in_valid / in_stall     in_char_code, in_is_last
//  out_     source     out_valid / out_stall   out_byte, out_byte_valid, out_done_res,
//                                              out_status, out_byte_total
//  cfg_     sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One character is taken per cycle unless stalled; the input register holds it, and its
// result, if it has one, is registered in the result register that drives out_valid.
// The decode step (table lookup, 6-bit shift, byte select) sits between the input
// register and the result register and sets the single-cycle rate.
// Reset is synchronous, active low; it clears the message state and the stage valids
// and loads the mode register with 0 and the limit register with 64.
// A result-side stall with a result held holds the result and input registers; the
// input side stalls only when its register holds a character that cannot advance.
// Characters that produce no result still pass through the decode step and update state.
`default_nettype none
module base64_stream_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_is_last,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [7:0]  out_byte,
  output      logic        out_byte_valid,
  output      logic        out_done_res,
  output      logic [1:0]  out_status,
  output      logic [12:0] out_byte_total,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  import b64d_pkg::*;

  cfg_t  cfg;
  item_t s1_item_r;
  logic  s1_vld_r, s1_vld_nxt;
  logic  s1_adv, in_xfer;
  logic  res_valid;
  res_t  res;
  logic  ov_r, ov_nxt;
  res_t  ores_r;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  b64d_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // advance the held character when the result register is free or draining
  assign s1_adv   = s1_vld_r && (!ov_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_xfer) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.char_code <= in_char_code;
      s1_item_r.is_last   <= in_is_last;
    end
  end

  b64d_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_adv),
    .item      (s1_item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // load a new result on advance, drop the old one once transferred
  always_comb begin
    ov_nxt = ov_r;
    if (s1_adv) begin
      ov_nxt = res_valid;
    end else if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ores_r <= res;
    end
  end

  assign out_valid      = ov_r;
  assign out_byte       = ores_r.out_byte;
  assign out_byte_valid = ores_r.byte_valid;
  assign out_done_res   = ores_r.done_res;
  assign out_status     = ores_r.status;
  assign out_byte_total = ores_r.byte_total;

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the base64 stream decoder top level.
`timescale 1ns / 100ps
module tb;
  import b64d_pkg::*;

  // Register indexes and modes that the package leaves unnamed.
  localparam logic [1:0] CFG_SPARE    = 2'd2;
  localparam logic [1:0] MODE_URL_ALT = 2'd3;
  // Cycles to let a no-result character clear the pipeline before a write.
  localparam int PipeDrain = 6;
  localparam int SegItems = 205;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [12:0] data;
    logic [7:0]  c;
    bit          last;
    bit          known;
    res_t        want;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_char_code = 8'd0;
  logic        in_is_last = 1'b0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = CFG_MODE;
  logic [12:0] cfg_data = 13'd0;
  wire         in_stall;
  wire         out_valid;
  wire  [7:0]  out_byte;
  wire         out_byte_valid;
  wire         out_done_res;
  wire  [1:0]  out_status;
  wire  [12:0] out_byte_total;
  wire         cfg_ready;

  // Own copy of the configuration and the message state.
  logic [1:0]  cfg_mode = MODE_STD;
  logic [12:0] cfg_limit = LimitReset;
  logic [13:0] acc_bits = '0;
  logic [3:0]  held_bits = '0;
  bit          pad_hit = 1'b0;
  status_t     msg_status = ST_OK;
  logic [1:0]  char_phase = '0;
  logic [12:0] emitted = '0;

  res_t        decoded_q[$];
  stim_row_t   plan[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  base64_stream_decoder_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_done_res   (out_done_res),
    .out_status     (out_status),
    .out_byte_total (out_byte_total),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Decode one character; return 1 when it yields a result.
  function automatic bit decode_char(input logic [7:0] c, input bit last, output res_t r);
    bit          strict;
    bit          skip_ws;
    bit          good;
    bit          take;
    bit          have;
    logic [5:0]  v;
    logic [7:0]  b;
    logic [12:0] lim;
    strict  = (cfg_mode == MODE_STRICT);
    skip_ws = (cfg_mode == MODE_STD);
    lim     = (cfg_limit > MaxTotal) ? MaxTotal : cfg_limit;
    good = 1'b1;
    take = 1'b1;
    have = 1'b0;
    v = 6'd0;
    b = 8'd0;
    r = '0;
    char_phase = char_phase + 2'd1;

    // Map either alphabet to its sextet; anything else, 128 and up included, is bad.
    if (c >= "A" && c <= "Z") begin
      v = 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      v = 6'(c - "a" + 26);
    end else if (c >= "0" && c <= "9") begin
      v = 6'(c - "0" + 52);
    end else if (c == CH_PLUS || c == CH_DASH) begin
      v = 6'd62;
    end else if (c == CH_SLASH || c == CH_USCORE) begin
      v = 6'd63;
    end else begin
      good = 1'b0;
    end

    // The first error sticks; padding mutes the rest of the message.
    if (msg_status != ST_OK) begin
      take = 1'b0;
    end else if (strict) begin
      if (c == CH_PLUS || c == CH_SLASH || c == CH_EQ || !good) begin
        msg_status = ST_BAD_CHAR;
        take = 1'b0;
      end
    end else if (pad_hit) begin
      take = 1'b0;
    end else if (c == CH_EQ) begin
      pad_hit = 1'b1;
      take = 1'b0;
    end else if (skip_ws && c <= CH_SPACE) begin
      take = 1'b0;
    end else if (!good) begin
      msg_status = ST_BAD_CHAR;
      take = 1'b0;
    end

    // Shift the sextet in; a full byte leaves whether or not the limit drops it.
    if (take) begin
      acc_bits  = {acc_bits[7:0], v};
      held_bits = held_bits + 4'd6;
      if (held_bits >= 4'd8) begin
        b = 8'(acc_bits >> (held_bits - 4'd8));
        held_bits = held_bits - 4'd8;
        if (emitted < lim) begin
          have = 1'b1;
          emitted = emitted + 13'd1;
        end
      end
    end

    // Strict end checks: length first, then the unused tail bits.
    if (last && strict && msg_status == ST_OK) begin
      if (char_phase == 2'd1) begin
        msg_status = ST_BAD_LEN;
      end else if (char_phase == 2'd2 && v[3:0] != 4'd0) begin
        msg_status = ST_BAD_TAIL;
      end else if (char_phase == 2'd3 && v[1:0] != 2'd0) begin
        msg_status = ST_BAD_TAIL;
      end
    end

    if (!last) begin
      r.out_byte   = b;
      r.byte_valid = 1'b1;
      r.status     = ST_OK;
      return have;
    end

    if (msg_status != ST_OK) have = 1'b0;
    r.out_byte   = have ? b : 8'd0;
    r.byte_valid = have;
    r.done_res   = 1'b1;
    r.status     = msg_status;
    r.byte_total = (msg_status == ST_OK) ? emitted : 13'd0;
    acc_bits   = '0;
    held_bits  = '0;
    pad_hit    = 1'b0;
    msg_status = ST_OK;
    char_phase = '0;
    emitted    = '0;
    return 1'b1;
  endfunction

  function automatic res_t outcome(input logic [7:0] b, input bit bv, input bit done,
                                   input status_t st, input logic [12:0] total);
    res_t r;
    r.out_byte   = b;
    r.byte_valid = bv;
    r.done_res   = done;
    r.status     = st;
    r.byte_total = total;
    return r;
  endfunction

  function automatic logic [7:0] char_of(input logic [5:0] v, input bit url);
    if (v < 6'd26) return 8'("A" + v);
    if (v < 6'd52) return 8'("a" + v - 26);
    if (v < 6'd62) return 8'("0" + v - 52);
    if (v == 6'd62) return url ? CH_DASH : CH_PLUS;
    return url ? CH_USCORE : CH_SLASH;
  endfunction

  // Mode write with junk in the unused upper data bits.
  function automatic logic [12:0] mode_word(input logic [1:0] m);
    return {11'($urandom), m};
  endfunction

  function automatic void add_row(input bit is_cfg, input logic [1:0] idx,
                                  input logic [12:0] data, input logic [7:0] c,
                                  input bit last, input bit known, input res_t want);
    stim_row_t row;
    row.is_cfg = is_cfg;
    row.idx    = idx;
    row.data   = data;
    row.c      = c;
    row.last   = last;
    row.known  = known;
    row.want   = want;
    plan.push_back(row);
  endfunction

  function automatic void add_char(input logic [7:0] c, input bit last);
    add_row(1'b0, CFG_MODE, 13'd0, c, last, 1'b0, '0);
  endfunction

  function automatic void add_known(input logic [7:0] c, input bit last, input res_t want);
    add_row(1'b0, CFG_MODE, 13'd0, c, last, 1'b1, want);
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input logic [12:0] data);
    add_row(1'b1, idx, data, 8'd0, 1'b0, 1'b0, '0);
  endfunction

  // Offer one character at a falling edge, after a random idle gap, and hold it
  // until the transfer; predict at the edge that takes it.
  task automatic send_char(input logic [7:0] c, input bit last, input bit known,
                           input res_t want);
    res_t got;
    bit   produced;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_is_last   <= last;
    do @(posedge clk); while (in_stall);
    produced = decode_char(c, last, got);
    if (known) begin
      decoded_q.push_back(want);
    end else if (produced) begin
      decoded_q.push_back(got);
    end
  endtask

  // Drop valid, drain every expected result, then let silent characters clear.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (PipeDrain) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MODE) begin
      cfg_mode = data[1:0];
    end else if (idx == CFG_LIMIT) begin
      cfg_limit = data;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Build one message: mostly well-formed with random content, the rest broken.
  task automatic random_message(inout int sent);
    logic [7:0] msg[$];
    int         n;
    int         split;
    bit         clean;
    bit         url;
    bit         strict;
    logic [5:0] v;
    strict = (cfg_mode == MODE_STRICT);
    clean  = ($urandom_range(99) < 80);
    url    = strict || ($urandom_range(1) == 1);
    // Keep most messages short; a few run past the small output limits.
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    if (clean && strict && n % 4 == 1) n++;
    for (int i = 0; i < n; i++) begin
      v = 6'($urandom);
      // Zero the unused low bits of the final sextet on clean messages.
      if (clean && i == n - 1) begin
        if (n % 4 == 2) begin
          v[3:0] = 4'd0;
        end else if (n % 4 == 3) begin
          v[1:0] = 2'd0;
        end
      end
      msg.push_back(char_of(v, url));
      if (cfg_mode == MODE_STD && $urandom_range(9) == 0) begin
        msg.push_back(8'($urandom_range(CH_SPACE)));
      end
    end
    // Pad to a full quantum in the lenient modes, sometimes with junk after it.
    if (!strict && n % 4 != 0 && $urandom_range(1) == 1) begin
      repeat (4 - n % 4) msg.push_back(CH_EQ);
      if ($urandom_range(3) == 0) msg.push_back(8'($urandom));
    end
    if (!clean) begin
      repeat ($urandom_range(1, 3)) msg[$urandom_range(msg.size() - 1)] = 8'($urandom);
    end
    // Now and then switch the mode halfway through the message.
    split = ($urandom_range(29) == 0) ? msg.size() / 2 : -1;
    foreach (msg[i]) begin
      if (i == split && i > 0) begin
        settle();
        write_reg(CFG_MODE, mode_word(2'($urandom_range(3))));
      end
      send_char(msg[i], i == msg.size() - 1, 1'b0, '0);
      sent++;
    end
  endtask

  // Receiver: stall at random, decided at each falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare every result transfer against the oldest expectation.
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: byte %02h done %0d", out_byte, out_done_res);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte);
          errors++;
        end
        if (out_byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %0d, got %0d", want.byte_valid, out_byte_valid);
          errors++;
        end
        if (out_done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, out_done_res);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_byte_total !== want.byte_total) begin
          $error("byte_total: expected %0d, got %0d", want.byte_total, out_byte_total);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [12:0] limit_plan[8];
    int          sent;
    int          blk;
    limit_plan = '{13'd64, 13'd0, 13'h1FFF, 13'd1, MaxTotal, 13'd3, 13'd17, LimitReset};

    // Directed table. Reset defaults first: standard mode, limit 64.
    add_char("T", 1'b0);
    add_known("W", 1'b0, outcome(8'h4D, 1'b1, 1'b0, ST_OK, 13'd0));
    add_known("F", 1'b0, outcome(8'h61, 1'b1, 1'b0, ST_OK, 13'd0));
    add_known("u", 1'b1, outcome(8'h6E, 1'b1, 1'b1, ST_OK, 13'd3));
    add_known(8'hFF, 1'b1, outcome(8'h00, 1'b0, 1'b1, ST_BAD_CHAR, 13'd0));
    // Control character skipped, all-ones byte, then padding mutes the rest.
    add_char(8'h00, 1'b0);
    add_char(CH_SLASH, 1'b0);
    add_known("w", 1'b0, outcome(8'hFF, 1'b1, 1'b0, ST_OK, 13'd0));
    add_char(CH_EQ, 1'b0);
    add_known("A", 1'b1, outcome(8'h00, 1'b0, 1'b1, ST_OK, 13'd1));
    // Lenient url: url alphabet, high characters and spaces are bad.
    add_cfg(CFG_MODE, {11'd0, MODE_URL});
    add_char(CH_DASH, 1'b0);
    add_char(CH_USCORE, 1'b1);
    add_known(8'h80, 1'b1, outcome(8'h00, 1'b0, 1'b1, ST_BAD_CHAR, 13'd0));
    add_known(CH_SPACE, 1'b1, outcome(8'h00, 1'b0, 1'b1, ST_BAD_CHAR, 13'd0));
    add_char(CH_EQ, 1'b0);
    add_char(8'hFF, 1'b1);
    // Strict url: standard symbols, lone characters and dirty tails.
    add_cfg(CFG_MODE, {11'd0, MODE_STRICT});
    add_known(CH_PLUS, 1'b1, outcome(8'h00, 1'b0, 1'b1, ST_BAD_CHAR, 13'd0));
    add_known("A", 1'b1, outcome(8'h00, 1'b0, 1'b1, ST_BAD_LEN, 13'd0));
    add_char("A", 1'b0);
    add_known("B", 1'b1, outcome(8'h00, 1'b0, 1'b1, ST_BAD_TAIL, 13'd0));
    add_char(CH_DASH, 1'b0);
    add_char(CH_USCORE, 1'b0);
    add_char(CH_EQ, 1'b1);
    // Mode 3 falls back to lenient url.
    add_cfg(CFG_MODE, {11'd0, MODE_URL_ALT});
    add_char(CH_USCORE, 1'b1);
    // Zero limit drops every byte; the largest limit saturates.
    add_cfg(CFG_MODE, {11'd0, MODE_STD});
    add_cfg(CFG_LIMIT, 13'd0);
    add_char("T", 1'b0);
    add_known("W", 1'b1, outcome(8'h00, 1'b0, 1'b1, ST_OK, 13'd0));
    add_cfg(CFG_LIMIT, 13'h1FFF);
    add_char("T", 1'b0);
    add_char("W", 1'b1);

    // Hold reset, then release it at a falling edge.
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_char(plan[i].c, plan[i].last, plan[i].known, plan[i].want);
      end
    end

    // A write to an unmapped index must leave both registers alone.
    settle();
    write_reg(CFG_SPARE, 13'($urandom));

    // Random segments, one idling pattern and one limit each.
    for (int seg = 0; seg < 8; seg++) begin
      settle();
      case (seg % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 77;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 77;
        end
        default: begin
          send_idle_pct = 29;
          recv_stall_pct = 29;
        end
      endcase
      write_reg(CFG_LIMIT, limit_plan[seg]);
      sent = 0;
      blk = 0;
      while (sent < SegItems) begin
        // Advance to a fresh mode every few messages.
        if (blk % 6 == 0) begin
          settle();
          write_reg(CFG_MODE, mode_word(2'($urandom_range(3))));
        end
        random_message(sent);
        blk++;
      end
    end

    // Drop valid, drain, then keep watching for stray transfers.
    @(negedge clk);
    in_valid <= 1'b0;
    for (int k = 0; k < 100000 && decoded_q.size() != 0; k++) @(posedge clk);
    repeat (PipeDrain + 2) @(posedge clk);
    if (decoded_q.size() != 0) begin
      $error("results missing: %0d still expected", decoded_q.size());
      errors += decoded_q.size();
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/b64d_pkg.sv
hdl/b64d_cfg.sv
hdl/b64d_core.sv
hdl/base64_stream_decoder_top.sv
bench/tb.sv
